FILE: rtl/first_fit_rectangle_placer_core_macros.svh
// assertion macros used by the checker
`ifndef FIRST_FIT_RECTANGLE_PLACER_CORE_MACROS_SVH
`define FIRST_FIT_RECTANGLE_PLACER_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define FFRP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define FFRP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ffrp_pkg.sv
package ffrp_pkg;

  localparam int COORD_BITS    = 12;
  localparam int CANVAS_BITS   = COORD_BITS + 1;
  localparam int MAX_RECTS_DEF = 64;

  localparam int CFG_IDX_BITS  = 1;
  localparam int CFG_DATA_BITS = 13;

  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_W = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_CANVAS_H = 1'b1;

  localparam logic [CFG_DATA_BITS-1:0] CANVAS_W_RST = 13'd800;
  localparam logic [CFG_DATA_BITS-1:0] CANVAS_H_RST = 13'd600;
  localparam logic [CANVAS_BITS-1:0]   CANVAS_MAX   = CANVAS_BITS'(1 << COORD_BITS);

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_CLEAR = 1'b1;

  typedef struct packed {
    logic                  opcode;
    logic [COORD_BITS-1:0] rect_width;
    logic [COORD_BITS-1:0] rect_height;
  } in_word_t;

  typedef struct packed {
    logic                  placed;
    logic [COORD_BITS-1:0] pos_x;
    logic [COORD_BITS-1:0] pos_y;
    logic                  table_full;
  } out_word_t;

  typedef struct packed {
    logic [COORD_BITS-1:0] x;
    logic [COORD_BITS-1:0] y;
    logic [COORD_BITS-1:0] w;
    logic [COORD_BITS-1:0] h;
  } rect_t;

  // one candidate origin walking down the chain
  typedef struct packed {
    logic                   valid;
    logic [COORD_BITS-1:0]  x;
    logic [COORD_BITS-1:0]  y;
    logic                   hit;
    logic [CANVAS_BITS-1:0] edge_x;
  } tok_t;

  function automatic logic [CANVAS_BITS-1:0] clamp_canvas(
    input logic [CFG_DATA_BITS-1:0] v
  );
    logic [31:0] v32;
    v32 = 32'(v);
    if (v32 > 32'(CANVAS_MAX)) begin
      return CANVAS_MAX;
    end
    return v32[CANVAS_BITS-1:0];
  endfunction

endpackage

FILE: rtl/ffrp_cell.sv
// one stored rectangle; tests the passing candidate against it
module ffrp_cell (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            active,
  input  logic                            wr_en,
  input  ffrp_pkg::rect_t                 wr_rect,
  input  logic [ffrp_pkg::COORD_BITS-1:0] cand_w,
  input  logic [ffrp_pkg::COORD_BITS-1:0] cand_h,
  input  ffrp_pkg::tok_t                  tok_in,
  output ffrp_pkg::tok_t                  tok_out
);

  ffrp_pkg::rect_t rect_r;
  ffrp_pkg::tok_t  tok_r, tok_nxt;

  logic [ffrp_pkg::CANVAS_BITS-1:0] ent_ex, ent_ey, cand_ex, cand_ey;
  logic                             ov;

  always_comb begin
    ent_ex  = {1'b0, rect_r.x} + {1'b0, rect_r.w};
    ent_ey  = {1'b0, rect_r.y} + {1'b0, rect_r.h};
    cand_ex = {1'b0, tok_in.x} + {1'b0, cand_w};
    cand_ey = {1'b0, tok_in.y} + {1'b0, cand_h};
    ov = tok_in.valid && active &&
         (|rect_r.w) && (|rect_r.h) && (|cand_w) && (|cand_h) &&
         ({1'b0, tok_in.x} < ent_ex) && ({1'b0, rect_r.x} < cand_ex) &&
         ({1'b0, tok_in.y} < ent_ey) && ({1'b0, rect_r.y} < cand_ey);
    tok_nxt = tok_in;
    // first blocker on the way sets the skip target
    if (ov && !tok_in.hit) begin
      tok_nxt.hit    = 1'b1;
      tok_nxt.edge_x = ent_ex;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      rect_r <= wr_rect;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_out = tok_r;

endmodule

FILE: rtl/first_fit_rectangle_placer_core.sv
// channel  | ports                          | word
// ---------+--------------------------------+----------------------------------
// input    | start, busy, in_data           | opcode, rect_width, rect_height
// result   | out_valid, out_data            | placed, pos_x, pos_y, table_full
// config   | cfg_we, cfg_idx, cfg_wdata     | canvas_width, canvas_height
//
// a word is taken when start is high and busy is low; clear, table full and an
// empty canvas answer on the next cycle without going busy
// a place word goes busy; each origin test is one pass through the cell
// chain, which carries up to MAX_RECTS rows at once; busy lasts until no
// pass is left in the chain and a row has fitted or every row has been
// tried, and each extra pass that a blocked origin needs holds back the answer
// reset is synchronous on rst_n: table empty, canvas 800 x 600, idle
// the result word is on out_data for one cycle with out_valid; it cannot stall
module first_fit_rectangle_placer_core #(
  parameter int MAX_RECTS = ffrp_pkg::MAX_RECTS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ffrp_pkg::CFG_IDX_BITS-1:0]  cfg_idx,
  input  logic [ffrp_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
  input  logic                               start,
  input  ffrp_pkg::in_word_t                 in_data,
  output logic                               busy,
  output logic                               out_valid,
  output ffrp_pkg::out_word_t                out_data
);

  localparam int CNT_BITS = $clog2(MAX_RECTS + 1);
  localparam int IDX_BITS = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam logic [CNT_BITS-1:0] FULL_CNT = CNT_BITS'(MAX_RECTS);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_SCAN = 1'b1;

  // control state
  logic                               state_r, state_nxt;
  logic [CNT_BITS-1:0]                count_r, count_nxt;
  logic [CNT_BITS-1:0]                inflight_r, inflight_nxt;
  logic [ffrp_pkg::CANVAS_BITS-1:0]   next_row_r, next_row_nxt;
  logic                               found_r, found_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [ffrp_pkg::CFG_DATA_BITS-1:0] cw_reg_r, cw_reg_nxt;
  logic [ffrp_pkg::CFG_DATA_BITS-1:0] ch_reg_r, ch_reg_nxt;

  // payload
  logic [ffrp_pkg::COORD_BITS-1:0]    w_r, w_nxt, h_r, h_nxt;
  logic [ffrp_pkg::COORD_BITS-1:0]    best_x_r, best_x_nxt, best_y_r, best_y_nxt;
  ffrp_pkg::out_word_t                out_r, out_nxt;

  logic [ffrp_pkg::CANVAS_BITS-1:0]   cw, ch;
  ffrp_pkg::tok_t                     chain_in  [MAX_RECTS];
  ffrp_pkg::tok_t                     chain_out [MAX_RECTS];
  ffrp_pkg::tok_t                     exit_tok, inject_tok;
  ffrp_pkg::rect_t                    wr_rect;
  logic                               place_wr;
  logic                               row_end, drop, reinject, retire, launch, done;
  logic                               better;

  assign cw = ffrp_pkg::clamp_canvas(cw_reg_r);
  assign ch = ffrp_pkg::clamp_canvas(ch_reg_r);

  // cell chain: tokens run cell 0 .. MAX_RECTS-1 and loop back through inject
  assign chain_in[0] = inject_tok;
  assign exit_tok    = chain_out[MAX_RECTS-1];
  assign wr_rect     = '{x: best_x_r, y: best_y_r, w: w_r, h: h_r};

  for (genvar i = 0; i < MAX_RECTS; i++) begin : g_cell
    if (i > 0) begin : g_link
      assign chain_in[i] = chain_out[i-1];
    end
    ffrp_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .active  (CNT_BITS'(i) < count_r),
      .wr_en   (place_wr && (count_r[IDX_BITS-1:0] == IDX_BITS'(i))),
      .wr_rect (wr_rect),
      .cand_w  (w_r),
      .cand_h  (h_r),
      .tok_in  (chain_in[i]),
      .tok_out (chain_out[i])
    );
  end

  // token leaving the chain: row found, row exhausted, dropped or sent round again
  always_comb begin
    row_end  = exit_tok.valid && exit_tok.hit && (exit_tok.edge_x >= cw);
    // rows below a found row can no longer win
    drop     = exit_tok.valid && exit_tok.hit && !row_end &&
               found_r && (exit_tok.y > best_y_r);
    reinject = exit_tok.valid && exit_tok.hit && !row_end && !drop;
    retire   = exit_tok.valid && !reinject;
    better   = exit_tok.valid && !exit_tok.hit && (!found_r || (exit_tok.y < best_y_r));
    launch   = (state_r == ST_SCAN) && !reinject && !found_r && (next_row_r < ch);
    done     = (state_r == ST_SCAN) && (inflight_r == '0) &&
               (found_r || (next_row_r >= ch));

    inject_tok = '0;
    if (reinject) begin
      inject_tok.valid = 1'b1;
      inject_tok.x     = exit_tok.edge_x[ffrp_pkg::COORD_BITS-1:0];
      inject_tok.y     = exit_tok.y;
    end else if (launch) begin
      inject_tok.valid = 1'b1;
      inject_tok.y     = next_row_r[ffrp_pkg::COORD_BITS-1:0];
    end
  end

  // sequencing
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    inflight_nxt  = inflight_r + CNT_BITS'(launch) - CNT_BITS'(retire);
    next_row_nxt  = next_row_r + ffrp_pkg::CANVAS_BITS'(launch);
    found_nxt     = found_r || better;
    best_x_nxt    = better ? exit_tok.x : best_x_r;
    best_y_nxt    = better ? exit_tok.y : best_y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    place_wr      = 1'b0;
    cw_reg_nxt    = cw_reg_r;
    ch_reg_nxt    = ch_reg_r;

    if (cfg_we) begin
      case (cfg_idx)
        ffrp_pkg::REG_CANVAS_W: cw_reg_nxt = cfg_wdata;
        ffrp_pkg::REG_CANVAS_H: ch_reg_nxt = cfg_wdata;
        default: ;
      endcase
    end

    case (state_r)
      ST_IDLE: begin
        if (start) begin
          out_nxt = '0;
          if (in_data.opcode == ffrp_pkg::OP_CLEAR) begin
            count_nxt     = '0;
            out_valid_nxt = 1'b1;
          end else if (count_r == FULL_CNT) begin
            out_nxt.table_full = 1'b1;
            out_valid_nxt      = 1'b1;
          end else if ((cw == '0) || (ch == '0)) begin
            // no origins to scan
            out_valid_nxt = 1'b1;
          end else begin
            state_nxt    = ST_SCAN;
            w_nxt        = in_data.rect_width;
            h_nxt        = in_data.rect_height;
            next_row_nxt = '0;
            inflight_nxt = '0;
            found_nxt    = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (done) begin
          state_nxt     = ST_IDLE;
          out_valid_nxt = 1'b1;
          out_nxt       = '0;
          if (found_r) begin
            out_nxt.placed = 1'b1;
            out_nxt.pos_x  = best_x_r;
            out_nxt.pos_y  = best_y_r;
            place_wr       = 1'b1;
            count_nxt      = count_r + CNT_BITS'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      inflight_r  <= '0;
      next_row_r  <= '0;
      found_r     <= 1'b0;
      out_valid_r <= 1'b0;
      cw_reg_r    <= ffrp_pkg::CANVAS_W_RST;
      ch_reg_r    <= ffrp_pkg::CANVAS_H_RST;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      inflight_r  <= inflight_nxt;
      next_row_r  <= next_row_nxt;
      found_r     <= found_nxt;
      out_valid_r <= out_valid_nxt;
      cw_reg_r    <= cw_reg_nxt;
      ch_reg_r    <= ch_reg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r      <= w_nxt;
    h_r      <= h_nxt;
    best_x_r <= best_x_nxt;
    best_y_r <= best_y_nxt;
    out_r    <= out_nxt;
  end

  assign busy      = (state_r == ST_SCAN);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

FILE: rtl/ffrp_checker.sv
`include "first_fit_rectangle_placer_core_macros.svh"

module ffrp_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input ffrp_pkg::in_word_t  in_data,
  input logic                out_valid,
  input ffrp_pkg::out_word_t out_data
);

  `FFRP_ASSERT_NEXT(a_clear_answers, start && !busy && (in_data.opcode == ffrp_pkg::OP_CLEAR), out_valid && (out_data == '0), "clear word not answered with zeros on the next cycle")
  `FFRP_ASSERT_NOW(a_placed_not_full, out_valid, !(out_data.placed && out_data.table_full), "result both placed and refused as full")
  `FFRP_ASSERT_NOW(a_miss_zero_pos, out_valid && !out_data.placed, (out_data.pos_x == '0) && (out_data.pos_y == '0), "unplaced result carries an origin")
  `FFRP_ASSERT_NOW(a_result_idle, out_valid, !busy, "result word while still searching")

endmodule

bind first_fit_rectangle_placer_core ffrp_checker u_ffrp_checker (.*);
